[hdl/nps_pkg.sv]
// nps_pkg: sizes, codes and helper functions for the nearest point search block
// no dependencies; used by hdl/nearest_point_search.sv and verif/tb_nearest_point_search.sv
`default_nettype none

package nps_pkg;

  // table geometry
  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // coordinate and offset formats
  localparam int COORD_W = 15;
  localparam int OFFS_W  = 16;
  localparam int DIST_W  = 32;
  localparam int ENTRY_W = 2 * COORD_W;
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(25600);

  // command carried in tuser
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // clamp a coordinate code to 100.0
  function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
    sat_coord = (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

endpackage

`default_nettype wire

[hdl/nearest_point_search.sv]
// nearest_point_search: point table in a registered-read memory with a pipelined nearest scan
// results: an add gives its result in the cycle after it is taken; a query on N stored
//   points gives its result once every point has been read and passed the scan stages
// throughput: adds 1 per cycle while the result side accepts; a query holds the input side
//   until its result is loaded, set by the single read port of the point memory, one point per cycle
// reset: point count and control cleared at once; memory contents are not cleared
`default_nettype none

module nearest_point_search (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  // input items
  input  wire  logic        s_axis_tvalid,
  output       logic        s_axis_tready,
  input  wire  logic [31:0] s_axis_tdata,  // pos_x [14:0], pos_y [29:15], zero [31:30]
  input  wire  logic [0:0]  s_axis_tuser,  // cmd [0]
  // result items
  output       logic        m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output       logic [31:0] m_axis_tdata,  // offset_x [15:0], offset_y [31:16]
  output       logic [1:0]  m_axis_tuser   // status [1:0]
);

  localparam int CW = nps_pkg::COORD_W;
  localparam int AW = nps_pkg::ADDR_W;
  localparam int NW = nps_pkg::CNT_W;
  localparam int OW = nps_pkg::OFFS_W;
  localparam int DW = nps_pkg::DIST_W;
  localparam int EW = nps_pkg::ENTRY_W;

  nps_pkg::state_e state_q, state_d;

  logic [NW-1:0] cnt_q;
  logic [NW-1:0] iss_cnt_q;
  logic [CW-1:0] qx_q, qy_q;

  logic          s_accept;
  logic          out_free;
  logic          out_load;
  logic [OW-1:0] out_x_d, out_y_d;
  logic [1:0]    out_st_d;
  logic          out_valid_q;
  logic [2*OW-1:0] out_data_q;
  logic [1:0]    out_user_q;

  logic          issue;
  logic          scan_idle;
  logic          mem_we;
  logic [EW-1:0] mem [nps_pkg::MAX_POINTS];
  logic [EW-1:0] rd_data_q;
  logic          rd_vld_q;

  logic                 v1_q, v2_q;
  logic signed [OW-1:0] dx_q, dy_q, dx2_q, dy2_q;
  logic signed [DW-1:0] sqx, sqy;
  logic [DW-1:0]        dist_q;
  logic                 have_q;
  logic [DW-1:0]        best_q;
  logic [OW-1:0]        bdx_q, bdy_q;

  logic [CW-1:0] in_x, in_y;
  logic          is_full;

  assign in_x     = nps_pkg::sat_coord(s_axis_tdata[CW-1:0]);
  assign in_y     = nps_pkg::sat_coord(s_axis_tdata[2*CW-1:CW]);
  assign is_full  = (cnt_q >= NW'(nps_pkg::MAX_POINTS));
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == nps_pkg::ST_IDLE) && out_free;
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign issue    = (state_q == nps_pkg::ST_SCAN) && (iss_cnt_q < cnt_q);
  assign scan_idle = !issue && !rd_vld_q && !v1_q && !v2_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nps_pkg::ST_IDLE: begin
        if (s_accept && s_axis_tuser[0] == nps_pkg::CMD_QUERY && cnt_q != '0) begin
          state_d = nps_pkg::ST_SCAN;
        end
      end
      nps_pkg::ST_SCAN: begin
        if (scan_idle) state_d = nps_pkg::ST_DONE;
      end
      nps_pkg::ST_DONE: begin
        if (out_free) state_d = nps_pkg::ST_IDLE;
      end
      default: state_d = nps_pkg::ST_IDLE;
    endcase
  end

  // memory write and result selection
  always_comb begin
    mem_we        = 1'b0;
    out_load      = 1'b0;
    out_x_d       = '0;
    out_y_d       = '0;
    out_st_d      = nps_pkg::STATUS_OK;
    case (state_q)
      nps_pkg::ST_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser[0] == nps_pkg::CMD_ADD) begin
            out_load = 1'b1;
            if (is_full) out_st_d = nps_pkg::STATUS_FULL;
            else         mem_we   = 1'b1;
          end else if (cnt_q == '0) begin
            out_load = 1'b1;
            out_st_d = nps_pkg::STATUS_EMPTY;
          end
        end
      end
      nps_pkg::ST_DONE: begin
        out_load = out_free;
        out_x_d  = bdx_q;
        out_y_d  = bdy_q;
      end
      default: ;
    endcase
  end

  // state, count and query registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nps_pkg::ST_IDLE;
      cnt_q     <= '0;
      iss_cnt_q <= '0;
      rd_vld_q  <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      have_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      v1_q     <= rd_vld_q;
      v2_q     <= v1_q;
      if (mem_we) cnt_q <= cnt_q + NW'(1);
      if (s_accept) begin
        iss_cnt_q <= '0;
        have_q    <= 1'b0;
      end else begin
        if (issue) iss_cnt_q <= iss_cnt_q + NW'(1);
        if (v2_q)  have_q    <= 1'b1;
      end
    end
  end

  // query point capture
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      qx_q <= in_x;
      qy_q <= in_y;
    end
  end

  // point memory: one write port for adds, one registered read port for the scan;
  // writes only happen while idle, so a scan never sees a write in flight
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cnt_q[AW-1:0]] <= {in_y, in_x};
    rd_data_q <= mem[iss_cnt_q[AW-1:0]];
  end

  // scan stage 1: offsets from the query point
  always_ff @(posedge clk_i) begin
    dx_q <= $signed({1'b0, rd_data_q[CW-1:0]}) - $signed({1'b0, qx_q});
    dy_q <= $signed({1'b0, rd_data_q[EW-1:CW]}) - $signed({1'b0, qy_q});
  end

  // scan stage 2: squared distance
  assign sqx = DW'(dx_q) * DW'(dx_q);
  assign sqy = DW'(dy_q) * DW'(dy_q);

  always_ff @(posedge clk_i) begin
    dist_q <= unsigned'(sqx) + unsigned'(sqy);
    dx2_q  <= dx_q;
    dy2_q  <= dy_q;
  end

  // scan stage 3: keep the best, strict compare so the earlier point wins a tie
  always_ff @(posedge clk_i) begin
    if (v2_q && (!have_q || dist_q < best_q)) begin
      best_q <= dist_q;
      bdx_q  <= dx2_q;
      bdy_q  <= dy2_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {out_y_d, out_x_d};
      out_user_q <= out_st_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // a result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result overwritten before it was taken");

  // the table is never written during a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != nps_pkg::ST_IDLE) |-> !mem_we)
    else $error("point memory written during a scan");

  // the scan pipeline is drained before the result is formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nps_pkg::ST_DONE) |-> (!rd_vld_q && !v1_q && !v2_q))
    else $error("result formed with points still in flight");

  // a stored add moves the count up by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (cnt_q == $past(cnt_q) + NW'(1)))
    else $error("point count did not follow an add");

  // the count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(nps_pkg::MAX_POINTS))
    else $error("point count above table size");

endmodule

`default_nettype wire

[verif/tb_nearest_point_search.sv]
// tb_nearest_point_search: self-checking bench for the nearest point search block
// drives adds and queries on the input stream, predicts each offset and status, checks results
// depends on hdl/nps_pkg.sv and hdl/nearest_point_search.sv

// point table model and the queue of offsets still owed by the block
class nearest_point_board;
  typedef struct packed {
    logic signed [nps_pkg::OFFS_W-1:0] off_x;
    logic signed [nps_pkg::OFFS_W-1:0] off_y;
    logic [1:0]                        status;
  } offset_result_t;

  logic [nps_pkg::COORD_W-1:0] pt_x [nps_pkg::MAX_POINTS];
  logic [nps_pkg::COORD_W-1:0] pt_y [nps_pkg::MAX_POINTS];
  int unsigned    stored;
  offset_result_t pending_offsets [$];
  int unsigned    mismatches, checked, adds, drops, queries, empties;

  function new();
    stored     = 0;
    mismatches = 0;
    checked    = 0;
    adds       = 0;
    drops      = 0;
    queries    = 0;
    empties    = 0;
  endfunction

  // coordinates above 100.0 are pinned to 100.0
  function logic [nps_pkg::COORD_W-1:0] clamp_coord(input logic [nps_pkg::COORD_W-1:0] v);
    return (v > nps_pkg::COORD_MAX) ? nps_pkg::COORD_MAX : v;
  endfunction

  // accepted input item: update the table and queue the expected result
  function void note_item(input logic cmd, input logic [nps_pkg::COORD_W-1:0] raw_x,
                          input logic [nps_pkg::COORD_W-1:0] raw_y);
    logic [nps_pkg::COORD_W-1:0] qx, qy;
    offset_result_t res;
    longint best, sq_dist, dx, dy;
    int idx;
    qx = clamp_coord(raw_x);
    qy = clamp_coord(raw_y);
    res = '0;
    res.status = nps_pkg::STATUS_OK;
    best = 0;
    if (cmd == nps_pkg::CMD_ADD) begin
      adds++;
      if (stored >= nps_pkg::MAX_POINTS) begin
        res.status = nps_pkg::STATUS_FULL;
        drops++;
      end else begin
        pt_x[stored] = qx;
        pt_y[stored] = qy;
        stored++;
      end
    end else begin
      queries++;
      if (stored == 0) begin
        res.status = nps_pkg::STATUS_EMPTY;
        empties++;
      end else begin
        // only a strictly closer point replaces the best, so earlier points win ties
        for (idx = 0; idx < int'(stored); idx++) begin
          dx      = longint'(pt_x[idx]) - longint'(qx);
          dy      = longint'(pt_y[idx]) - longint'(qy);
          sq_dist = dx * dx + dy * dy;
          if (idx == 0 || sq_dist < best) begin
            best      = sq_dist;
            res.off_x = dx[nps_pkg::OFFS_W-1:0];
            res.off_y = dy[nps_pkg::OFFS_W-1:0];
          end
        end
      end
    end
    pending_offsets.insert(pending_offsets.size(), res);
  endfunction

  // accepted result item: compare with the oldest expected one
  function void check_item(input logic [31:0] data, input logic [1:0] user);
    offset_result_t want;
    if (pending_offsets.size() == 0) begin
      $error("result with no item pending: offset_x %0d offset_y %0d status %0d",
             $signed(data[15:0]), $signed(data[31:16]), user);
      mismatches++;
      return;
    end
    want = pending_offsets.pop_front();
    checked++;
    if (data[15:0] !== want.off_x) begin
      $error("offset_x mismatch: expected %0d, actual %0d", want.off_x, $signed(data[15:0]));
      mismatches++;
    end
    if (data[31:16] !== want.off_y) begin
      $error("offset_y mismatch: expected %0d, actual %0d", want.off_y, $signed(data[31:16]));
      mismatches++;
    end
    if (user !== want.status) begin
      $error("status mismatch: expected %0d, actual %0d", want.status, user);
      mismatches++;
    end
  endfunction
endclass

module tb_nearest_point_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 330;
  localparam int DRAIN_CYCLES  = 100;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // pos_x [14:0], pos_y [29:15], zero [31:30]
  logic [0:0]  s_axis_tuser  = nps_pkg::CMD_ADD;  // cmd [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // offset_x [15:0], offset_y [31:16]
  logic [1:0]  m_axis_tuser;  // status [1:0]

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 57;
  int unsigned stall_cycles  = 0;
  nearest_point_board board;

  nearest_point_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // both handshakes observed at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_item(m_axis_tdata, m_axis_tuser);
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      board.note_item(s_axis_tuser[0], s_axis_tdata[14:0], s_axis_tdata[29:15]);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("nearest_point_search verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // send one item, called at a falling edge, returns at a falling edge
  task automatic send_item(input logic cmd, input logic [nps_pkg::COORD_W-1:0] x,
                           input logic [nps_pkg::COORD_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // coordinate mix: in range, edges, out of range, and a coarse grid for distance ties
  function automatic logic [nps_pkg::COORD_W-1:0] pick_coord();
    int unsigned r;
    case ($urandom_range(9))
      0:       r = $urandom_range(32767, 25601);
      1:       r = $urandom_range(1) ? {17'd0, nps_pkg::COORD_MAX} : 0;
      2, 3, 4: r = $urandom_range(100) * 256;
      default: r = $urandom_range(25600);
    endcase
    return r[nps_pkg::COORD_W-1:0];
  endfunction

  initial begin
    int phase;
    int n;
    board = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, extremes, saturation and distance ties
    send_item(nps_pkg::CMD_QUERY, 15'd0, 15'd0);
    send_item(nps_pkg::CMD_QUERY, 15'h7fff, 15'h7fff);
    send_item(nps_pkg::CMD_ADD, 15'd0, 15'd0);
    send_item(nps_pkg::CMD_QUERY, nps_pkg::COORD_MAX, nps_pkg::COORD_MAX);
    send_item(nps_pkg::CMD_ADD, nps_pkg::COORD_MAX, nps_pkg::COORD_MAX);
    send_item(nps_pkg::CMD_ADD, 15'h7fff, 15'd25601);
    send_item(nps_pkg::CMD_QUERY, 15'd0, 15'd0);
    send_item(nps_pkg::CMD_QUERY, 15'h7fff, 15'd0);
    send_item(nps_pkg::CMD_QUERY, nps_pkg::COORD_MAX, nps_pkg::COORD_MAX);
    send_item(nps_pkg::CMD_ADD, 15'd100, 15'd100);
    send_item(nps_pkg::CMD_ADD, 15'd300, 15'd100);
    send_item(nps_pkg::CMD_QUERY, 15'd200, 15'd100);
    send_item(nps_pkg::CMD_ADD, 15'h5555, 15'h2aaa);
    send_item(nps_pkg::CMD_ADD, 15'h2aaa, 15'h5555);
    send_item(nps_pkg::CMD_QUERY, 15'h4000, 15'h4000);
    send_item(nps_pkg::CMD_QUERY, 15'd0, nps_pkg::COORD_MAX);

    // random: table fills gradually, then adds get dropped
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 37; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_item(($urandom_range(99) < 15) ? nps_pkg::CMD_ADD : nps_pkg::CMD_QUERY,
                  pick_coord(), pick_coord());
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then leave room for any stray result
    while (board.pending_offsets.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d adds (%0d dropped on a full table), %0d queries (%0d on empty table)",
             board.adds, board.drops, board.queries, board.empties);
    $display("%0d results compared, %0d mismatching fields", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_offsets.size() == 0) begin
      $display("nearest_point_search verification clean");
    end else begin
      $display("nearest_point_search verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/nps_pkg.sv
hdl/nearest_point_search.sv
verif/tb_nearest_point_search.sv
